[hw/rtl/fcgi_rc_pkg.sv]
package fcgi_rc_pkg;

  localparam int NumKeys = 6;

  // Key names as ASCII bytes, left aligned in 16 bytes, zero filled.
  localparam logic [127:0] KEY_TXT [NumKeys] = '{
    {80'h5343_5249_5054_5F55_524C, 48'h0},
    {72'h48_5454_505F_484F_5354, 56'h0},
    {88'h4854_5450_5F41_4343_4550_54, 40'h0},
    {120'h48_5454_505F_5553_4552_5F41_4745_4E54, 8'h0},
    {120'h53_4552_5645_525F_534F_4654_5741_5245, 8'h0},
    {112'h5245_5155_4553_545F_4D45_5448_4F44, 16'h0}
  };
  localparam logic [7:0] KEY_LEN [NumKeys] = '{8'd10, 8'd9, 8'd11, 8'd15, 8'd15, 8'd14};

  // Key bit numbers
  localparam int KeyUrl    = 0;
  localparam int KeyHost   = 1;
  localparam int KeyAgent  = 3;
  localparam int KeyMethod = 5;

  localparam logic [7:0] REC_PARAMS = 8'd4;
  localparam logic [7:0] FCGI_VER   = 8'd1;
  localparam logic [7:0] TYPE_MAX   = 8'd11;

  localparam logic [2:0] V_UNDECIDED = 3'd0;
  localparam logic [2:0] V_EXCLUDED  = 3'd1;
  localparam logic [2:0] V_DETECTED  = 3'd2;
  localparam logic [2:0] V_MALFORMED = 3'd3;
  localparam logic [2:0] V_STOP      = 3'd4;

  typedef struct packed {
    logic [15:0] offset;
    logic [7:0]  length;
  } value_pos_t;

  function automatic logic [7:0] key_char(input int j, input logic [3:0] idx);
    logic [127:0] t;
    t = KEY_TXT[j] << {idx, 3'b000};
    return t[127:120];
  endfunction

endpackage

[hw/rtl/fastcgi_record_classifier_unit.sv]
// Channel  | Signals                                    | Direction
// ---------+--------------------------------------------+----------
// in       | in_valid/in_ready, data_byte, first_byte,  | input
//          | payload_length, packet_count               |
// out      | out_valid/out_ready, verdict ... lengths   | output
// cfg      | cfg_valid/cfg_ready, cfg_data              | input
//
// One byte per cycle while in_ready is high. Each accepted beat updates the
// parser state and, on the last payload byte, loads the result register; the
// result appears in the cycle after its byte. in_ready drops only while a
// result is held and out_ready is low. cfg_ready is always high. Synchronous
// active-high reset restores min_packets to 2 and clears the per-packet state.
module fastcgi_record_classifier_unit
  import fcgi_rc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic [15:0] payload_length,
  input  logic [7:0]  packet_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  verdict,
  output logic [7:0]  record_type,
  output logic [5:0]  keys_found,
  output logic [15:0] host_offset,
  output logic [7:0]  host_length,
  output logic [15:0] url_offset,
  output logic [7:0]  url_length,
  output logic [15:0] agent_offset,
  output logic [7:0]  agent_length,
  output logic [15:0] method_offset,
  output logic [7:0]  method_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  // params walk phases
  localparam logic [2:0] PH_KLEN  = 3'd0;
  localparam logic [2:0] PH_VLEN  = 3'd1;
  localparam logic [2:0] PH_KEY   = 3'd2;
  localparam logic [2:0] PH_VALUE = 3'd3;
  localparam logic [2:0] PH_BAD   = 3'd4;

  logic [7:0]  min_packets;
  logic [15:0] byte_position, byte_position_next;
  logic [7:0]  hb0, hb1, hb4, hb5, hb6;
  logic [7:0]  hb0_next, hb1_next, hb4_next, hb5_next, hb6_next;
  logic        header_failed, header_failed_next;
  logic [2:0]  phase, phase_next;
  logic [7:0]  klen, klen_next, vlen, vlen_next;
  logic [7:0]  field_offset, field_offset_next;
  logic [5:0]  cands, cands_next;
  logic        malformed, malformed_next;
  logic [5:0]  found, found_next;
  value_pos_t  vp_host, vp_url, vp_agent, vp_method;
  value_pos_t  vp_host_next, vp_url_next, vp_agent_next, vp_method_next;

  logic        accept;
  logic [15:0] p;
  logic        in_range, last_byte;
  logic [16:0] p_plus1;
  logic [17:0] pair_end;
  logic [7:0]  fo_inc;
  logic [5:0]  hit;
  value_pos_t  new_pos;

  // result datapath
  logic [2:0]  res_verdict;
  logic        res_show;
  logic [15:0] content;
  logic [16:0] total;
  logic        hdr_bad;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  assign p         = first_byte ? 16'd0 : byte_position;
  assign p_plus1   = {1'b0, p} + 17'd1;
  assign in_range  = p < payload_length;
  assign last_byte = in_range && (p_plus1 == {1'b0, payload_length});
  assign new_pos   = '{offset: p_plus1[15:0], length: vlen};

  always_comb begin
    byte_position_next = (p == 16'hFFFF) ? p : p_plus1[15:0];
    if (first_byte) begin
      hb0_next = '0; hb1_next = '0; hb4_next = '0; hb5_next = '0; hb6_next = '0;
      header_failed_next = 1'b0;
      phase_next = PH_KLEN;
      klen_next = '0; vlen_next = '0; field_offset_next = '0;
      cands_next = '0; malformed_next = 1'b0; found_next = '0;
      vp_host_next = '0; vp_url_next = '0; vp_agent_next = '0; vp_method_next = '0;
    end else begin
      hb0_next = hb0; hb1_next = hb1; hb4_next = hb4; hb5_next = hb5; hb6_next = hb6;
      header_failed_next = header_failed;
      phase_next = phase;
      klen_next = klen; vlen_next = vlen; field_offset_next = field_offset;
      cands_next = cands; malformed_next = malformed; found_next = found;
      vp_host_next = vp_host; vp_url_next = vp_url;
      vp_agent_next = vp_agent; vp_method_next = vp_method;
    end
    pair_end = {2'b00, p} + 18'd1 + {10'd0, klen} + {10'd0, data_byte};
    fo_inc   = field_offset + 8'd1;
    hit      = '0;

    if (in_range) begin
      if (p < 16'd8) begin
        case (p[2:0])
          3'd0: begin
            hb0_next = data_byte;
            if (data_byte != FCGI_VER) header_failed_next = 1'b1;
          end
          3'd1: begin
            hb1_next = data_byte;
            if (data_byte < 8'd1 || data_byte > TYPE_MAX) header_failed_next = 1'b1;
          end
          3'd4: hb4_next = data_byte;
          3'd5: hb5_next = data_byte;
          3'd6: hb6_next = data_byte;
          default: ;
        endcase
      end else begin
        // p >= 8 implies no first_byte, so stored state is current
        case (phase)
          PH_KLEN: begin
            if (p_plus1 + 17'd1 < {1'b0, payload_length}) begin
              klen_next  = data_byte;
              phase_next = PH_VLEN;
            end else begin
              malformed_next = 1'b1;
              phase_next     = PH_BAD;
            end
          end
          PH_VLEN: begin
            vlen_next = data_byte;
            if (pair_end > {2'b00, payload_length}) begin
              malformed_next = 1'b1;
              phase_next     = PH_BAD;
            end else begin
              for (int j = 0; j < NumKeys; j++)
                cands_next[j] = (KEY_LEN[j] == klen);
              field_offset_next = '0;
              if (klen != 8'd0) phase_next = PH_KEY;
              else if (data_byte != 8'd0) phase_next = PH_VALUE;
              else phase_next = PH_KLEN;
            end
          end
          PH_KEY: begin
            for (int j = 0; j < NumKeys; j++)
              cands_next[j] = cands[j] && (field_offset < KEY_LEN[j]) &&
                              (key_char(j, field_offset[3:0]) == data_byte);
            field_offset_next = fo_inc;
            if (fo_inc == klen) begin
              // lowest matching key wins
              for (int j = NumKeys - 1; j >= 0; j--)
                if (cands_next[j]) begin
                  hit    = '0;
                  hit[j] = 1'b1;
                end
              found_next = found | hit;
              if (hit[KeyUrl])    vp_url_next    = new_pos;
              if (hit[KeyHost])   vp_host_next   = new_pos;
              if (hit[KeyAgent])  vp_agent_next  = new_pos;
              if (hit[KeyMethod]) vp_method_next = new_pos;
              cands_next        = '0;
              field_offset_next = '0;
              phase_next        = (vlen != 8'd0) ? PH_VALUE : PH_KLEN;
            end
          end
          PH_VALUE: begin
            field_offset_next = fo_inc;
            if (fo_inc == vlen) begin
              field_offset_next = '0;
              phase_next        = PH_KLEN;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Verdict on the last byte; header registers are settled since p >= 7 there.
  always_comb begin
    content  = {hb4, hb5};
    total    = 17'd8 + {1'b0, content} + {9'd0, hb6};
    hdr_bad  = header_failed || hb0 != FCGI_VER || hb1 < 8'd1 || hb1 > TYPE_MAX ||
               total != {1'b0, payload_length};
    res_show = 1'b0;
    if (payload_length < 16'd8) begin
      res_verdict = V_EXCLUDED;
    end else if (hdr_bad) begin
      res_verdict = V_EXCLUDED;
    end else if (hb1 == REC_PARAMS) begin
      if (content == 16'd0) begin
        res_verdict = V_STOP;
      end else begin
        res_verdict = (malformed_next || phase_next != PH_KLEN) ? V_MALFORMED : V_DETECTED;
        res_show    = 1'b1;
      end
    end else begin
      res_verdict = (packet_count > min_packets) ? V_DETECTED : V_UNDECIDED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_packets   <= 8'd2;
      byte_position <= '0;
      hb0 <= '0; hb1 <= '0; hb4 <= '0; hb5 <= '0; hb6 <= '0;
      header_failed <= 1'b0;
      phase         <= PH_KLEN;
      klen <= '0; vlen <= '0; field_offset <= '0;
      cands <= '0; malformed <= 1'b0; found <= '0;
      vp_host <= '0; vp_url <= '0; vp_agent <= '0; vp_method <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) min_packets <= cfg_data;
      if (accept) begin
        byte_position <= byte_position_next;
        hb0 <= hb0_next; hb1 <= hb1_next; hb4 <= hb4_next;
        hb5 <= hb5_next; hb6 <= hb6_next;
        header_failed <= header_failed_next;
        phase         <= phase_next;
        klen <= klen_next; vlen <= vlen_next; field_offset <= field_offset_next;
        cands <= cands_next; malformed <= malformed_next; found <= found_next;
        vp_host <= vp_host_next; vp_url <= vp_url_next;
        vp_agent <= vp_agent_next; vp_method <= vp_method_next;
      end
      if (accept && last_byte) out_valid <= 1'b1;
      else if (out_ready)      out_valid <= 1'b0;
    end
  end

  // result register, loaded only with a fresh beat
  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      verdict       <= res_verdict;
      record_type   <= (payload_length < 16'd8) ? 8'd0 : hb1;
      keys_found    <= res_show ? found_next : 6'd0;
      host_offset   <= res_show ? vp_host_next.offset : 16'd0;
      host_length   <= res_show ? vp_host_next.length : 8'd0;
      url_offset    <= res_show ? vp_url_next.offset : 16'd0;
      url_length    <= res_show ? vp_url_next.length : 8'd0;
      agent_offset  <= res_show ? vp_agent_next.offset : 16'd0;
      agent_length  <= res_show ? vp_agent_next.length : 8'd0;
      method_offset <= res_show ? vp_method_next.offset : 16'd0;
      method_length <= res_show ? vp_method_next.length : 8'd0;
    end
  end

endmodule
